// ===== hdl/diff_drive_odometry_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the odometry unit
// Short forms for same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define DDO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants, tables, types and helpers of the odometry unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddo_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN         = 30;
   localparam int ATAN_IW          = 5;
   localparam int CS_W             = 33;   // CORDIC datapath, Q2.30 plus sign
   localparam int DIV_NUM_W        = 52;
   localparam int DIV_DEN_W        = 32;
   localparam int DIV_LANES        = 5;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 24;

   // divider lane assignment
   localparam int LANE_SPD_L  = 0;
   localparam int LANE_SPD_R  = 1;
   localparam int LANE_RATE_X = 2;
   localparam int LANE_RATE_Y = 3;
   localparam int LANE_TURN   = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MPC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TPC = 2'd1;

   localparam logic [CSR_DATA_W-1:0] MPC_RESET = 24'd542000;
   localparam logic [CSR_DATA_W-1:0] TPC_RESET = 24'd191700;

   localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [17:0]            TWO_PI_Q15  = 18'd205887;
   localparam logic [9:0]             MS_PER_S    = 10'd1000;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
      30'd536870912, 30'd316933405, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465,  30'd10680350,  30'd5340245,   30'd2670163,  30'd1335086,
      30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41721,
      30'd20860,     30'd10430,     30'd5215,      30'd2607,     30'd1303,
      30'd651,       30'd325,       30'd162,       30'd81,       30'd40,
      30'd20,        30'd10,        30'd5,         30'd2,        30'd1
   };

   typedef struct packed {
      logic                   done;
      logic signed [CS_W-1:0] cos_v;
      logic signed [CS_W-1:0] sin_v;
   } cordic_res_type;

   // Saturate a sign and magnitude to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic neg, input logic [DIV_NUM_W-1:0] m);
      logic [31:0] r;
      if (neg) begin
         r = (m >= DIV_NUM_W'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-m);
      end else begin
         r = (m >= DIV_NUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, cos and sin
// of a binary angle, both in Q2.30. Results hold until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_cordic import ddo_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [31:0]    angle,
   output cordic_res_type res
);

   localparam int IW = $clog2(CORDIC_STEPS);

   logic signed [CS_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [IW-1:0]          i_ff, i_in;
   logic                   busy_ff, busy_in, done_ff, done_in, flip_ff, flip_in;
   logic signed [CS_W-1:0] z0, xs, ys, at;

   // fold the angle into the right half plane
   always_comb begin
      z0 = {angle[31], angle};
      if (z0 > 33'sd1073741824) begin
         z0 = z0 - 33'sd2147483648;
      end else if (z0 < -33'sd1073741824) begin
         z0 = z0 + 33'sd2147483648;
      end
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      at = $signed({3'b000, ATAN_TAB[ATAN_IW'(i_ff)]});
   end

   // advance one micro-rotation
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = z0;
         flip_in = (angle[31:30] == 2'b01 && angle[29:0] != '0) ||
                   (angle[31:30] == 2'b10);
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[CS_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == IW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      i_ff    <= i_in;
      flip_ff <= flip_in;
   end

   assign res.done  = done_ff;
   assign res.cos_v = flip_ff ? -x_ff : x_ff;
   assign res.sin_v = flip_ff ? -y_ff : y_ff;

endmodule

// ===== hdl/ddo_div_bank.sv =====
// ----------------------------------------------------------------------------
// ddo_div_bank
// Bank of restoring dividers sharing one divisor and one step counter;
// each lane retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_div_bank import ddo_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num [DIV_LANES],
   input  logic [DIV_DEN_W-1:0] den,
   output logic [DIV_NUM_W-1:0] quot [DIV_LANES],
   output logic                 done
);

   localparam int CW = $clog2(DIV_NUM_W);

   logic [DIV_NUM_W-1:0] qn_ff [DIV_LANES];
   logic [DIV_NUM_W-1:0] qn_in [DIV_LANES];
   logic [DIV_DEN_W-1:0] rem_ff [DIV_LANES];
   logic [DIV_DEN_W-1:0] rem_in [DIV_LANES];
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   // sequence the bit steps
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // shift in one numerator bit and trial-subtract per lane
   for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
      logic [DIV_DEN_W:0] r2;
      always_comb begin
         r2        = {rem_ff[l], qn_ff[l][DIV_NUM_W-1]};
         qn_in[l]  = qn_ff[l];
         rem_in[l] = rem_ff[l];
         if (start) begin
            qn_in[l]  = num[l];
            rem_in[l] = '0;
         end else if (busy_ff) begin
            if (r2 >= {1'b0, den_ff}) begin
               rem_in[l] = DIV_DEN_W'(r2 - {1'b0, den_ff});
               qn_in[l]  = {qn_ff[l][DIV_NUM_W-2:0], 1'b1};
            end else begin
               rem_in[l] = r2[DIV_DEN_W-1:0];
               qn_in[l]  = {qn_ff[l][DIV_NUM_W-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         qn_ff[l]  <= qn_in[l];
         rem_ff[l] <= rem_in[l];
      end
      assign quot[l] = qn_ff[l];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      if (start) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;

endmodule

// ===== hdl/diff_drive_odometry_unit.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry_unit
// Differential-drive wheel odometry: pose, wheel speeds, body twist and
// half-angle quaternion from encoder counts and a millisecond timestamp.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            beat
//  req      in   req_valid/req_stall  left_count, right_count, time_ms
//  rsp      out  rsp_valid/rsp_stall  pose, speeds, rates, quaternion, no_time
//  csr      in   csr_we               csr_index, csr_wdata
//
// A beat passes MUL1, ROT1 (CORDIC on the old heading), MUL2, POSE, DLOAD, DIV
// (divider bank, CORDIC on the half heading) and TURN before the result loads.
// One beat is in work at a time; req_stall is high until the result is loaded.
// A finished result waits in the output register while the next beat enters.
// Synchronous active-high reset clears pose and history, sets register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "diff_drive_odometry_unit_macros.svh"

module diff_drive_odometry_unit import ddo_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [15:0]    req_left_count,
   input  logic signed [15:0]    req_right_count,
   input  logic [31:0]           req_time_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_pos_x,
   output logic signed [31:0]    rsp_pos_y,
   output logic [31:0]           rsp_heading,
   output logic signed [31:0]    rsp_speed_left,
   output logic signed [31:0]    rsp_speed_right,
   output logic signed [31:0]    rsp_rate_x,
   output logic signed [31:0]    rsp_rate_y,
   output logic signed [31:0]    rsp_turn_rate,
   output logic signed [15:0]    rsp_quat_z,
   output logic signed [15:0]    rsp_quat_w,
   output logic                  rsp_no_time,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MUL1  = 9'b000000010,
      ST_ROT1  = 9'b000000100,
      ST_MUL2  = 9'b000001000,
      ST_POSE  = 9'b000010000,
      ST_DLOAD = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_TURN  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] mpc_ff, tpc_ff;
   logic [15:0]           prev_left_ff, prev_right_ff;
   logic [31:0]           prev_time_ff, dt_ff;
   logic [31:0]           pose_x_ff, pose_y_ff, heading_ff;
   logic signed [16:0]    dl_ff, dr_ff;
   logic signed [42:0]    dist_raw_ff, turn_raw_ff;
   logic signed [41:0]    spdl_raw_ff, spdr_raw_ff;
   logic [24:0]           dist_mag_ff;
   logic                  dist_neg_ff, spdl_neg_ff, spdr_neg_ff, turn_neg_ff;
   logic [DIV_NUM_W-1:0]  num_ff [DIV_LANES];
   logic [26:0]           stepx_mag_ff, stepy_mag_ff;
   logic                  stepx_neg_ff, stepy_neg_ff;
   logic [63:0]           tprod_ff;

   logic signed [31:0]    rsp_pos_x_ff, rsp_pos_y_ff, rsp_spd_l_ff, rsp_spd_r_ff;
   logic signed [31:0]    rsp_rate_x_ff, rsp_rate_y_ff, rsp_turn_ff;
   logic [31:0]           rsp_heading_ff;
   logic signed [15:0]    rsp_qz_ff, rsp_qw_ff;
   logic                  rsp_no_time_ff, rsp_valid_ff;

   logic                  accept, load_out;
   logic                  cordic_start, cordic_wait;
   logic [31:0]           cordic_angle;
   cordic_res_type        cres;
   logic [DIV_NUM_W-1:0]  quot [DIV_LANES];
   logic                  div_done;

   logic signed [17:0]    wsum, wdiff;
   logic [42:0]           dist_abs, turn_abs;
   logic [41:0]           spdl_abs, spdr_abs;
   logic [31:0]           cos_abs, sin_abs;
   logic [31:0]           stepx_s, stepy_s;
   logic [45:0]           b_clamp;
   logic signed [33:0]    qz_sum, qw_sum;
   logic signed [18:0]    qz_r, qw_r;
   logic [15:0]           qz_sat, qw_sat;
   logic                  no_time;

   assign accept   = req_valid && !req_stall;
   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // advance the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) begin
            state_in = ST_MUL1;
         end
         ST_MUL1:  state_in = ST_ROT1;
         ST_ROT1:  if (cres.done) begin
            state_in = ST_MUL2;
         end
         ST_MUL2:  state_in = ST_POSE;
         ST_POSE:  state_in = ST_DLOAD;
         ST_DLOAD: state_in = ST_DIV;
         ST_DIV:   if (div_done) begin
            state_in = ST_TURN;
         end
         ST_TURN:  state_in = ST_DONE;
         ST_DONE:  if (load_out) begin
            state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // shared CORDIC: old heading first, then half of the new heading
   assign cordic_start = (state_ff == ST_MUL1) || (state_ff == ST_DLOAD);
   assign cordic_wait  = (state_ff == ST_ROT1) || (state_ff == ST_DIV);
   assign cordic_angle = (state_ff == ST_MUL1) ? heading_ff : {1'b0, heading_ff[31:1]};

   ddo_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (cordic_angle),
      .res   (cres)
   );

   ddo_div_bank u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_DLOAD),
      .num   (num_ff),
      .den   (dt_ff),
      .quot  (quot),
      .done  (div_done)
   );

   // datapath helpers
   always_comb begin
      wsum     = {dl_ff[16], dl_ff} + {dr_ff[16], dr_ff};
      wdiff    = {dr_ff[16], dr_ff} - {dl_ff[16], dl_ff};
      dist_abs = dist_raw_ff[42] ? 43'(-dist_raw_ff) : 43'(dist_raw_ff);
      turn_abs = turn_raw_ff[42] ? 43'(-turn_raw_ff) : 43'(turn_raw_ff);
      spdl_abs = spdl_raw_ff[41] ? 42'(-spdl_raw_ff) : 42'(spdl_raw_ff);
      spdr_abs = spdr_raw_ff[41] ? 42'(-spdr_raw_ff) : 42'(spdr_raw_ff);
      cos_abs  = cres.cos_v[CS_W-1] ? 32'(-cres.cos_v) : cres.cos_v[31:0];
      sin_abs  = cres.sin_v[CS_W-1] ? 32'(-cres.sin_v) : cres.sin_v[31:0];
      stepx_s  = stepx_neg_ff ? 32'(-{5'b0, stepx_mag_ff}) : {5'b0, stepx_mag_ff};
      stepy_s  = stepy_neg_ff ? 32'(-{5'b0, stepy_mag_ff}) : {5'b0, stepy_mag_ff};
      b_clamp  = (quot[LANE_TURN][DIV_NUM_W-1:45] != '0) ? {1'b1, 45'b0}
                                                        : quot[LANE_TURN][45:0];
      no_time  = (dt_ff == '0);
      // round the half-angle sin and cos to Q1.15
      qz_sum   = {cres.sin_v[CS_W-1], cres.sin_v} + 34'sd16384;
      qw_sum   = {cres.cos_v[CS_W-1], cres.cos_v} + 34'sd16384;
      qz_r     = qz_sum[33:15];
      qw_r     = qw_sum[33:15];
      if (qz_r > 19'sd32767) begin
         qz_sat = 16'h7FFF;
      end else if (qz_r < -19'sd32768) begin
         qz_sat = 16'h8000;
      end else begin
         qz_sat = qz_r[15:0];
      end
      if (qw_r > 19'sd32767) begin
         qw_sat = 16'h7FFF;
      end else if (qw_r < -19'sd32768) begin
         qw_sat = 16'h8000;
      end else begin
         qw_sat = qw_r[15:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         mpc_ff        <= MPC_RESET;
         tpc_ff        <= TPC_RESET;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         prev_time_ff  <= '0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         heading_ff    <= '0;
      end else begin
         state_ff <= state_in;
         // hold the result until taken
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we && csr_index == CSR_MPC) begin
            mpc_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_TPC) begin
            tpc_ff <= csr_wdata;
         end
         if (accept) begin
            prev_left_ff  <= req_left_count;
            prev_right_ff <= req_right_count;
            prev_time_ff  <= req_time_ms;
         end
         // advance the pose with the old heading
         if (state_ff == ST_POSE) begin
            pose_x_ff  <= pose_x_ff + stepx_s;
            pose_y_ff  <= pose_y_ff + stepy_s;
            heading_ff <= heading_ff + turn_raw_ff[31:0];
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         dl_ff <= {req_left_count[15], req_left_count} - {prev_left_ff[15], prev_left_ff};
         dr_ff <= {req_right_count[15], req_right_count} - {prev_right_ff[15], prev_right_ff};
         dt_ff <= req_time_ms - prev_time_ff;
      end
      if (state_ff == ST_MUL1) begin
         dist_raw_ff <= wsum * $signed({1'b0, mpc_ff});
         turn_raw_ff <= wdiff * $signed({1'b0, tpc_ff});
         spdl_raw_ff <= dl_ff * $signed({1'b0, mpc_ff});
         spdr_raw_ff <= dr_ff * $signed({1'b0, mpc_ff});
      end
      if (state_ff == ST_ROT1) begin
         dist_mag_ff            <= dist_abs[41:17];
         dist_neg_ff            <= dist_raw_ff[42];
         spdl_neg_ff            <= spdl_raw_ff[41];
         spdr_neg_ff            <= spdr_raw_ff[41];
         turn_neg_ff            <= turn_raw_ff[42];
         num_ff[LANE_SPD_L]     <= DIV_NUM_W'((51'(spdl_abs[40:0]) * 51'(MS_PER_S)) >> 16);
         num_ff[LANE_SPD_R]     <= DIV_NUM_W'((51'(spdr_abs[40:0]) * 51'(MS_PER_S)) >> 16);
         num_ff[LANE_TURN]      <= DIV_NUM_W'(turn_abs[40:0]) * DIV_NUM_W'(MS_PER_S);
      end
      if (state_ff == ST_MUL2) begin
         stepx_mag_ff <= 27'((57'(dist_mag_ff) * 57'(cos_abs)) >> 30);
         stepy_mag_ff <= 27'((57'(dist_mag_ff) * 57'(sin_abs)) >> 30);
         stepx_neg_ff <= dist_neg_ff ^ cres.cos_v[CS_W-1];
         stepy_neg_ff <= dist_neg_ff ^ cres.sin_v[CS_W-1];
      end
      if (state_ff == ST_POSE) begin
         num_ff[LANE_RATE_X] <= DIV_NUM_W'(37'(stepx_mag_ff) * 37'(MS_PER_S));
         num_ff[LANE_RATE_Y] <= DIV_NUM_W'(37'(stepy_mag_ff) * 37'(MS_PER_S));
      end
      if (state_ff == ST_TURN) begin
         tprod_ff <= 64'(b_clamp) * 64'(TWO_PI_Q15);
      end
      // load the output beat
      if (load_out) begin
         rsp_pos_x_ff   <= pose_x_ff;
         rsp_pos_y_ff   <= pose_y_ff;
         rsp_heading_ff <= heading_ff;
         rsp_spd_l_ff   <= no_time ? '0 : sat32(spdl_neg_ff, quot[LANE_SPD_L]);
         rsp_spd_r_ff   <= no_time ? '0 : sat32(spdr_neg_ff, quot[LANE_SPD_R]);
         rsp_rate_x_ff  <= no_time ? '0 : sat32(stepx_neg_ff, quot[LANE_RATE_X]);
         rsp_rate_y_ff  <= no_time ? '0 : sat32(stepy_neg_ff, quot[LANE_RATE_Y]);
         rsp_turn_ff    <= no_time ? '0 :
                           sat32(turn_neg_ff, DIV_NUM_W'(tprod_ff[63:31]));
         rsp_qz_ff      <= qz_sat;
         rsp_qw_ff      <= qw_sat;
         rsp_no_time_ff <= no_time;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_pos_x_ff;
   assign rsp_pos_y       = rsp_pos_y_ff;
   assign rsp_heading     = rsp_heading_ff;
   assign rsp_speed_left  = rsp_spd_l_ff;
   assign rsp_speed_right = rsp_spd_r_ff;
   assign rsp_rate_x      = rsp_rate_x_ff;
   assign rsp_rate_y      = rsp_rate_y_ff;
   assign rsp_turn_rate   = rsp_turn_ff;
   assign rsp_quat_z      = rsp_qz_ff;
   assign rsp_quat_w      = rsp_qw_ff;
   assign rsp_no_time     = rsp_no_time_ff;

   // checks
   `DDO_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == ST_MUL1, "no start")
   `DDO_ASSERT_NOW(a_cordic_done_state, clock, reset, cres.done, cordic_wait, "stray CORDIC done")
   `DDO_ASSERT_NOW(a_div_done_state, clock, reset, div_done, state_ff == ST_DIV, "stray div done")
   `DDO_ASSERT_NEXT(a_load_shows, clock, reset, load_out, rsp_valid, "result not presented")

endmodule

// ===== bench/ddo_odometry_checker.sv =====
// ----------------------------------------------------------------------------
// ddo_odometry_checker
// Watches the sample, result and register ports of the odometry unit. It
// keeps its own copy of the registers, pose and sample history, works out
// the result of each accepted sample beat, and compares every result beat
// field by field with the oldest result still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_odometry_checker import ddo_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic signed [15:0]    req_left_count,
   input  logic signed [15:0]    req_right_count,
   input  logic [31:0]           req_time_ms,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic signed [31:0]    rsp_pos_x,
   input  logic signed [31:0]    rsp_pos_y,
   input  logic [31:0]           rsp_heading,
   input  logic signed [31:0]    rsp_speed_left,
   input  logic signed [31:0]    rsp_speed_right,
   input  logic signed [31:0]    rsp_rate_x,
   input  logic signed [31:0]    rsp_rate_y,
   input  logic signed [31:0]    rsp_turn_rate,
   input  logic signed [15:0]    rsp_quat_z,
   input  logic signed [15:0]    rsp_quat_w,
   input  logic                  rsp_no_time,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    awaited
);

   typedef struct {
      logic [31:0] pos_x, pos_y, heading;
      logic [31:0] speed_left, speed_right, rate_x, rate_y, turn_rate;
      logic [15:0] quat_z, quat_w;
      logic        no_time;
   } odo_beat_type;

   odo_beat_type        pending_odo[$];
   logic [23:0]         travel_scale;
   logic [23:0]         turn_scale;
   logic signed [15:0]  last_left, last_right;
   logic [31:0]         hist_time;
   logic [31:0]         pose_x, pose_y, pose_hd;

   assign awaited = pending_odo.size();

   function automatic longint unsigned mag(input longint v);
      return (v < 0) ? longint'(0) - v : v;
   endfunction

   function automatic logic [31:0] clamp32(input bit neg, input longint unsigned m);
      if (neg)
         return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(m));
      return (m >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
   endfunction

   function automatic logic [31:0] rate_of(input longint num, input longint unsigned den);
      return clamp32(num < 0, mag(num) * 1000 / den);
   endfunction

   // rotation-mode CORDIC on a binary angle, Q2.30 out
   function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit     flip;
      z = longint'(signed'(ang));
      flip = 0;
      x = longint'(CORDIC_GAIN);
      y = 0;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648;
         flip = 1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_LEN; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= longint'(ATAN_TAB[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += longint'(ATAN_TAB[i]);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint scale_q30(input longint a, input longint b);
      longint unsigned m;
      m = (mag(a) * mag(b)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [15:0] quat_q15(input longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // advance the pose by one sample and form its result
   function automatic odo_beat_type advance_pose(input logic signed [15:0] l,
                                                 input logic signed [15:0] r,
                                                 input logic [31:0] t);
      odo_beat_type      o;
      logic [31:0]       dt;
      longint            dl, dr, dist_raw, turn_raw, travel, c, s, sx, sy, qc, qs;
      longint unsigned   b;
      dt = t - hist_time;
      dl = longint'(l) - longint'(last_left);
      dr = longint'(r) - longint'(last_right);
      dist_raw = (dl + dr) * longint'(travel_scale);
      turn_raw = (dr - dl) * longint'(turn_scale);
      travel = (dist_raw < 0) ? -longint'(mag(dist_raw) >> 17)
                              : longint'(mag(dist_raw) >> 17);
      rotate(pose_hd, c, s);
      sx = scale_q30(travel, c);
      sy = scale_q30(travel, s);
      pose_x  += sx[31:0];
      pose_y  += sy[31:0];
      pose_hd += turn_raw[31:0];
      o.speed_left = 0;
      o.speed_right = 0;
      o.rate_x = 0;
      o.rate_y = 0;
      o.turn_rate = 0;
      if (dt != 0) begin
         o.speed_left  = rate_of(dl * longint'(travel_scale), {16'b0, dt, 16'b0});
         o.speed_right = rate_of(dr * longint'(travel_scale), {16'b0, dt, 16'b0});
         o.rate_x = rate_of(sx, {32'b0, dt});
         o.rate_y = rate_of(sy, {32'b0, dt});
         b = mag(turn_raw) * 1000 / {32'b0, dt};
         if (b >= (64'd1 << 45))
            o.turn_rate = clamp32(turn_raw < 0, 64'd1 << 40);
         else
            o.turn_rate = clamp32(turn_raw < 0, (b * 205887) >> 31);
      end
      rotate(pose_hd >> 1, qc, qs);
      o.quat_z = quat_q15(qs);
      o.quat_w = quat_q15(qc);
      o.no_time = (dt == 0);
      o.pos_x = pose_x;
      o.pos_y = pose_y;
      o.heading = pose_hd;
      last_left = l;
      last_right = r;
      hist_time = t;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      odo_beat_type w;
      if (reset) begin
         travel_scale = MPC_RESET;
         turn_scale = TPC_RESET;
         last_left = '0;
         last_right = '0;
         hist_time = '0;
         pose_x = '0;
         pose_y = '0;
         pose_hd = '0;
         pending_odo.delete();
      end else begin
         // compare an outgoing result beat
         if (rsp_valid && !rsp_stall) begin
            if (pending_odo.size() == 0) begin
               $display("%0t: result beat with none awaited, expected none, actual x=%h",
                        $time, rsp_pos_x);
               fail_count++;
            end else begin
               w = pending_odo.pop_front();
               check_field("pos_x", w.pos_x, rsp_pos_x);
               check_field("pos_y", w.pos_y, rsp_pos_y);
               check_field("heading", w.heading, rsp_heading);
               check_field("speed_left", w.speed_left, rsp_speed_left);
               check_field("speed_right", w.speed_right, rsp_speed_right);
               check_field("rate_x", w.rate_x, rsp_rate_x);
               check_field("rate_y", w.rate_y, rsp_rate_y);
               check_field("turn_rate", w.turn_rate, rsp_turn_rate);
               check_field("quat_z", {16'b0, w.quat_z}, {16'b0, rsp_quat_z});
               check_field("quat_w", {16'b0, w.quat_w}, {16'b0, rsp_quat_w});
               check_field("no_time", {31'b0, w.no_time}, {31'b0, rsp_no_time});
            end
         end
         // track register writes
         if (csr_we) begin
            if (csr_index == CSR_MPC)
               travel_scale = csr_wdata;
            else if (csr_index == CSR_TPC)
               turn_scale = csr_wdata;
         end
         // predict an incoming sample beat
         if (req_valid && !req_stall)
            pending_odo.push_back(advance_pose(req_left_count, req_right_count, req_time_ms));
      end
   end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the odometry unit with directed and random encoder samples across
// several register settings and idle patterns; the checker beside the unit
// predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import ddo_pkg::*; ();

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   logic signed [15:0]    req_left_count = 0;
   logic signed [15:0]    req_right_count = 0;
   logic [31:0]           req_time_ms = 0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   logic signed [31:0]    rsp_pos_x, rsp_pos_y, rsp_speed_left, rsp_speed_right;
   logic signed [31:0]    rsp_rate_x, rsp_rate_y, rsp_turn_rate;
   logic [31:0]           rsp_heading;
   logic signed [15:0]    rsp_quat_z, rsp_quat_w;
   logic                  rsp_no_time;
   logic                  csr_we = 0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MPC;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;
   int                    fail_count, awaited;
   int                    send_idle_pct = 0, recv_idle_pct = 0;
   logic signed [15:0]    cur_left = 0, cur_right = 0;
   logic [31:0]           cur_time = 0;

   always #5 clock = ~clock;

   diff_drive_odometry_unit dut (.*);
   ddo_odometry_checker checker_i (.*);

   // receiver stall
   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);

   // present one sample beat and hold it until accepted
   task automatic send_sample(input logic signed [15:0] l, input logic signed [15:0] r,
                              input logic [31:0] t);
      req_left_count <= l;
      req_right_count <= r;
      req_time_ms <= t;
      req_valid <= 1;
      cur_left = l;
      cur_right = r;
      cur_time = t;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // drop valid and wait for every awaited result, then let the unit settle
   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // random sample: mostly small steps from the last one
   task automatic random_sample;
      logic signed [15:0] l, r;
      logic [31:0]        t;
      int                 kind;
      kind = $urandom_range(0, 99);
      l = cur_left + 16'($urandom_range(0, 400)) - 16'sd200;
      r = cur_right + 16'($urandom_range(0, 400)) - 16'sd200;
      t = cur_time + $urandom_range(1, 60);
      if (kind < 8) begin
         l = 16'($urandom);
         r = 16'($urandom);
      end else if (kind < 14) begin
         t = cur_time;
      end else if (kind < 18) begin
         t = $urandom;
      end else if (kind < 22) begin
         r = cur_right + 16'($urandom_range(0, 8000)) - 16'sd4000;
         t = cur_time + 1;
      end
      send_sample(l, r, t);
   endtask

   initial begin
      logic [23:0] mpc_set[5];
      logic [23:0] tpc_set[5];
      int          done_items;
      mpc_set = '{MPC_RESET, 24'd1, 24'hFFFFFF, 24'd0, 24'd0};
      tpc_set = '{TPC_RESET, 24'd1, 24'hFFFFFF, 24'd0, 24'd0};
      mpc_set[3] = 24'($urandom_range(1, 24'hFFFFFF));
      tpc_set[3] = 24'($urandom_range(1, 24'hFFFFFF));
      mpc_set[4] = 24'($urandom_range(1, 4000000));
      tpc_set[4] = 24'($urandom_range(1, 4000000));
      done_items = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, zero elapsed time, time wrap, big turns
      send_idle_pct = 9;
      recv_idle_pct = 77;
      send_sample(16'sd0, 16'sd0, 32'd0);
      send_sample(16'sd100, 16'sd100, 32'd10);
      send_sample(16'sd100, 16'sd100, 32'd10);
      send_sample(16'sd32767, 16'sd32767, 32'd11);
      send_sample(-16'sd32768, -16'sd32768, 32'd12);
      send_sample(16'sd32767, -16'sd32768, 32'd13);
      send_sample(-16'sd32768, 16'sd32767, 32'd14);
      send_sample(16'sd0, 16'sd0, 32'hFFFF_FFFF);
      send_sample(16'sd5, 16'sd5, 32'd3);
      send_sample(16'sd5, 16'sd5, 32'h8000_0000);
      send_sample(16'sd1000, 16'sd3000, 32'h8000_0001);
      send_sample(16'sd3000, 16'sd1000, 32'h8000_0002);
      send_sample(16'sd3001, 16'sd1002, 32'h8000_0002);
      send_sample(-16'sd1, 16'sd1, 32'h7FFF_FFFF);
      drain();
      // index beyond the registers is ignored
      write_reg(2'd2, 24'hFFFFFF);
      write_reg(2'd3, 24'h000001);

      for (int ph = 0; ph < 5; ph++) begin
         write_reg(CSR_MPC, mpc_set[ph]);
         write_reg(CSR_TPC, tpc_set[ph]);
         // large opposite wheel steps at each setting, saturating turn and speeds at big scales
         send_sample(cur_left - 16'sd30000, cur_right + 16'sd30000, cur_time + 1);
         send_sample(cur_left + 16'sd30000, cur_right - 16'sd30000, cur_time + 1);
         for (int n = 0; n < 360; n++) begin
            if (done_items < 600) begin
               send_idle_pct = 9;
               recv_idle_pct = 77;
            end else if (done_items < 1200) begin
               send_idle_pct = 77;
               recv_idle_pct = 9;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            random_sample();
            done_items++;
         end
         drain();
      end

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // guard against a hang
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ddo_pkg.sv
hdl/ddo_cordic.sv
hdl/ddo_div_bank.sv
hdl/diff_drive_odometry_unit.sv
bench/ddo_odometry_checker.sv
bench/tb.sv
